/* rtl/rtpsrb_pkg.sv */
// Shared types and constants for the RTP sequence reorder buffer.
// No dependencies; every other file imports this package.
package rtpsrb_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SEQ_W  = 16;
  localparam int HDL_W  = 16;
  localparam int LEN_W  = 11;

  typedef enum logic [0:0] {
    OP_PACKET = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LAST
  } state_e;

  // Descriptor kept per slot and carried on release
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [HDL_W-1:0] handle;
    logic [LEN_W-1:0] length;
  } slot_t;

  typedef struct packed {
    slot_t desc;
    logic  gap;
  } pend_t;

endpackage

/* rtl/rtpsrb_if.sv */
// Valid/ready channel interfaces for packet input and release output.
// Depends on rtpsrb_pkg for field widths.
interface rtpsrb_in_if import rtpsrb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [SEQ_W-1:0] seq_number;
  logic [HDL_W-1:0] buffer_handle;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, opcode, seq_number, buffer_handle, payload_length,
                  input ready);
  modport sink   (input valid, opcode, seq_number, buffer_handle, payload_length,
                  output ready);
endinterface

interface rtpsrb_out_if import rtpsrb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] out_seq;
  logic [HDL_W-1:0] out_handle;
  logic [LEN_W-1:0] out_length;
  logic             gap_reset;
  logic             last_of_run;

  modport source (output valid, out_seq, out_handle, out_length, gap_reset, last_of_run,
                  input ready);
  modport sink   (input valid, out_seq, out_handle, out_length, gap_reset, last_of_run,
                  output ready);
endinterface

/* rtl/rtp_sequence_reorder_buffer_top.sv */
// RTP sequence reorder buffer, top level.
// Depends on rtpsrb_pkg and the channel interfaces in rtpsrb_if.sv.

// Reorders packet descriptors (sequence number, buffer handle, payload length)
// by 16-bit RTP sequence number; payload bytes never pass through. The first
// packet after reset or a flush sets the expected number. A packet behind the
// expected number (ahead distance 0x8000..0xFFFF, modulo 2^16) is dropped with
// no transaction. A packet 1..SLOTS-1 ahead is stored in slot seq mod SLOTS,
// overwriting whatever sat there. The expected packet is released at once,
// followed by every stored in-order successor; last_of_run marks the final
// release of such a run. A packet SLOTS or more ahead clears all slots and is
// released alone with gap_reset and last_of_run set. A flush clears the slots
// and produces no transaction. A flush, store or drop leaves the input ready;
// a packet that releases descriptors stalls the input until its last release
// enters the output register, and back-pressure lengthens that stall. The
// descriptor store is a one-read, one-write synchronous RAM read once per cycle
// along the chain, and the release decision for each descriptor waits on the
// read of its successor. At most SLOTS descriptors leave per packet. A released
// transaction sits in an output register, so the input takes the next packet
// while the final release of a run still waits for the sink.
module rtp_sequence_reorder_buffer_top import rtpsrb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  rtpsrb_in_if.sink     in_i,
  rtpsrb_out_if.source  out_o
);

  state_e             state_q, state_d;
  logic [SEQ_W-1:0]   exp_q, exp_d;
  logic               await_q, await_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [CNT_W-1:0]   n_q, n_d;
  pend_t              pend_q, pend_d;

  // Descriptor RAM: one write port, one registered read port
  slot_t              mem_q [SLOTS];
  slot_t              rd_q;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [SLOT_W-1:0]  rd_addr;
  slot_t              wr_data;

  // Output register
  logic               out_valid_q;
  pend_t              out_q;
  logic               out_last_q;

  logic               in_fire;
  logic               push_ok;
  logic               push;
  logic               push_last;
  logic               rd_hit;
  logic [SEQ_W-1:0]   exp_base;
  logic [SEQ_W-1:0]   ahead;
  logic [SEQ_W-1:0]   seq_next;

  assign in_fire  = in_i.valid && in_i.ready;
  assign push_ok  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // First packet after reset or flush becomes its own expected number
  assign exp_base = await_q ? in_i.seq_number : exp_q;
  assign ahead    = in_i.seq_number - exp_base;
  assign seq_next = in_i.seq_number + SEQ_W'(1);

  // Read data belongs to exp_q: the address is always taken from exp_d
  assign rd_addr  = exp_d[SLOT_W-1:0];
  assign rd_hit   = valid_q[exp_q[SLOT_W-1:0]] && (rd_q.seq == exp_q) &&
                    (n_q < CNT_W'(SLOTS));

  assign wr_addr  = in_i.seq_number[SLOT_W-1:0];
  assign wr_data  = '{seq: in_i.seq_number, handle: in_i.buffer_handle,
                      length: in_i.payload_length};

  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    await_d   = await_q;
    valid_d   = valid_q;
    n_d       = n_q;
    pend_d    = pend_q;
    wr_en     = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (op_e'(in_i.opcode) == OP_FLUSH) begin
            // clear slots, rearm first-packet
            await_d = 1'b1;
            valid_d = '0;
          end else begin
            await_d = 1'b0;
            exp_d   = exp_base;
            if (ahead[SEQ_W-1]) begin
              // behind: drop
            end else if (ahead == '0) begin
              // in order: hold it until the successor lookup settles last_of_run
              pend_d  = '{desc: wr_data, gap: 1'b0};
              exp_d   = seq_next;
              n_d     = CNT_W'(1);
              state_d = ST_CHECK;
            end else if (ahead < SEQ_W'(SLOTS)) begin
              wr_en            = 1'b1;
              valid_d[wr_addr] = 1'b1;
            end else begin
              // gap too large: flush the window and release alone
              valid_d = '0;
              pend_d  = '{desc: wr_data, gap: 1'b1};
              exp_d   = seq_next;
              state_d = ST_LAST;
            end
          end
        end
      end

      ST_CHECK: begin
        if (push_ok) begin
          push      = 1'b1;
          push_last = !rd_hit;
          if (rd_hit) begin
            // advance along the chain, free the slot
            pend_d                            = '{desc: rd_q, gap: 1'b0};
            valid_d[exp_q[SLOT_W-1:0]]        = 1'b0;
            exp_d                             = exp_q + SEQ_W'(1);
            n_d                               = n_q + CNT_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_LAST: begin
        if (push_ok) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_q       <= '0;
      await_q     <= 1'b1;
      valid_q     <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      await_q <= await_d;
      valid_q <= valid_d;
      n_q     <= n_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_seq     = out_q.desc.seq;
  assign out_o.out_handle  = out_q.desc.handle;
  assign out_o.out_length  = out_q.desc.length;
  assign out_o.gap_reset   = out_q.gap;
  assign out_o.last_of_run = out_last_q;

endmodule

/* rtl/rtpsrb_checker.sv */
// Port-level assertions for the RTP sequence reorder buffer.
// Depends on rtpsrb_pkg; bound to rtp_sequence_reorder_buffer_top below.
module rtpsrb_checker import rtpsrb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SEQ_W-1:0] out_seq_i,
  input logic             gap_reset_i,
  input logic             last_of_run_i
);

  logic             open_q;
  logic [SEQ_W-1:0] prev_seq_q;

  // Track whether the last accepted release left a run open
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      prev_seq_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      open_q     <= !last_of_run_i;
      prev_seq_q <= out_seq_i;
    end
  end

  a_run_consecutive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && open_q |-> out_seq_i == prev_seq_q + SEQ_W'(1))
    else $error("release inside a run does not follow its predecessor");

  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && open_q |-> !gap_reset_i)
    else $error("gap reset inside an open run");

  a_gap_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gap_reset_i |-> last_of_run_i)
    else $error("gap reset release not marked last");

  a_stall_open_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> !in_ready_i)
    else $error("input taken while a run is still draining");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_seq_i))
    else $error("stalled release changed");

endmodule

bind rtp_sequence_reorder_buffer_top rtpsrb_checker u_rtpsrb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_seq_i    (out_o.out_seq),
  .gap_reset_i  (out_o.gap_reset),
  .last_of_run_i(out_o.last_of_run)
);
